[hdl/rgbrs_pkg.sv]
// Shared constants for the bilinear RGB resampler.
package rgbrs_pkg;

    localparam int CH_W       = 16;
    localparam int PIX_W      = 3 * CH_W;
    localparam int COORD_W    = 12;
    localparam int SRC_DIM_W  = 9;
    localparam int DST_DIM_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

    // reset values
    localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 9'd256;
    localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 9'd256;
    localparam logic [DST_DIM_W-1:0] DST_WIDTH_RST  = 13'd64;
    localparam logic [DST_DIM_W-1:0] DST_HEIGHT_RST = 13'd64;

    // operation and mode codes
    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_SAMPLE     = 1'b1;
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

endpackage

[hdl/rgbrs_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module rgbrs_div #(
    parameter int NW = 37,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            trial = {rem_in, num_in[NW-1]};
            ge    = trial >= {1'b0, i_den};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? DW'(trial - {1'b0, i_den}) : trial[DW-1:0];
            r_num[k] <= num_in << 1;
            r_quo[k] <= {quo_in[NW-2:0], ge};
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

[hdl/rgbrs_store.sv]
// Source frame store: four banks split by column and row parity.
module rgbrs_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [1:0]                          i_wbank,
    input  logic [AW-1:0]                       i_waddr,
    input  logic [rgbrs_pkg::PIX_W-1:0]         i_wdata,
    input  logic [3:0][AW-1:0]                  i_raddr,
    output logic [3:0][rgbrs_pkg::PIX_W-1:0]    o_rdata
);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [rgbrs_pkg::PIX_W-1:0] mem [DEPTH];
        logic [rgbrs_pkg::PIX_W-1:0] r_rdata;

        always_ff @(posedge i_clk) begin
            if (i_we && i_wbank == 2'(b)) begin
                mem[i_waddr] <= i_wdata;
            end
            r_rdata <= mem[i_raddr[b]];
        end

        assign o_rdata[b] = r_rdata;
    end

endmodule

[hdl/rgbrs_blend.sv]
// Two-stage bilinear blend: horizontal lerps, then vertical lerp.
module rgbrs_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [3:0][rgbrs_pkg::PIX_W-1:0]    i_pix,
    input  logic [FRAC_BITS-1:0]                i_dx,
    input  logic [FRAC_BITS-1:0]                i_dy,
    output logic                                o_valid,
    output logic [rgbrs_pkg::CH_W-1:0]          o_red,
    output logic [rgbrs_pkg::CH_W-1:0]          o_green,
    output logic [rgbrs_pkg::CH_W-1:0]          o_blue
);

    localparam int CW = rgbrs_pkg::CH_W;
    localparam int WW = FRAC_BITS + 1;
    localparam int HB = CW + FRAC_BITS + 1;
    localparam int AB = CW + 2 * FRAC_BITS + 2;
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    logic                    r_v1;
    logic                    r_v2;
    logic [FRAC_BITS-1:0]    r_dy;
    logic [2:0][CW-1:0]      chan_out;
    logic [WW-1:0]           wx0;
    logic [WW-1:0]           wy0;

    assign wx0 = ONE - WW'(i_dx);
    assign wy0 = ONE - WW'(r_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dy <= i_dy;
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [HB-1:0] r_h1;
        logic [HB-1:0] r_h2;
        logic [CW-1:0] r_out;
        logic [AB-1:0] acc;

        assign acc = AB'(r_h1) * AB'(wy0) + AB'(r_h2) * AB'(r_dy);

        always_ff @(posedge i_clk) begin
            // top pair then bottom pair, weighted across x
            r_h1  <= HB'(i_pix[0][c*CW +: CW]) * HB'(wx0)
                   + HB'(i_pix[1][c*CW +: CW]) * HB'(i_dx);
            r_h2  <= HB'(i_pix[2][c*CW +: CW]) * HB'(wx0)
                   + HB'(i_pix[3][c*CW +: CW]) * HB'(i_dx);
            r_out <= acc[2*FRAC_BITS +: CW];
        end

        assign chan_out[c] = r_out;
    end

    assign o_valid = r_v2;
    assign o_red   = chan_out[0];
    assign o_green = chan_out[1];
    assign o_blue  = chan_out[2];

endmodule

[hdl/bilinear_rgb_resampler.sv]
// Top level of the bilinear RGB resampler with four-bank source frame store.
//
// Usage: one request is taken on every clock where start is high (busy is
// always low, the pipeline never stalls). A load request (operation 0)
// writes an RGB pixel at (col, row) of the source frame if it lies inside
// src_width x src_height; it gives no result. A sample request (operation
// 1) maps destination (col, row) to a source position through a pipelined
// divider, one quotient bit per stage, and returns one pixel.
// Throughput: one request per cycle, loads and samples freely mixed. The
// divider depth sets the latency; the four banks (split by column and row
// parity) give all four neighbours in one read, so rate is one per cycle.
// Loads travel the same pipeline as samples, so store writes and reads keep
// request order. Result is on o_red_out/o_green_out/o_blue_out for exactly
// one cycle with o_strobe; the receiver cannot stall.
// Reset: synchronous, active low; clears the pipeline and restores the
// registers. The frame store is not cleared: only written pixels may be read.
// The user must write configuration through i_cfg_we/i_cfg_idx/i_cfg_data
// only while idle; the block itself does not enforce this.
module bilinear_rgb_resampler #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rgbrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rgbrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_operation,
    input  logic [rgbrs_pkg::COORD_W-1:0]        i_col,
    input  logic [rgbrs_pkg::COORD_W-1:0]        i_row,
    input  logic [rgbrs_pkg::CH_W-1:0]           i_red_in,
    input  logic [rgbrs_pkg::CH_W-1:0]           i_green_in,
    input  logic [rgbrs_pkg::CH_W-1:0]           i_blue_in,
    output logic                                 o_strobe,
    output logic [rgbrs_pkg::CH_W-1:0]           o_red_out,
    output logic [rgbrs_pkg::CH_W-1:0]           o_green_out,
    output logic [rgbrs_pkg::CH_W-1:0]           o_blue_out
);

    localparam int MAXD   = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
    localparam int SW     = $clog2(MAXD + 1);          // effective source size
    localparam int SW1    = SW + 1;
    localparam int PW     = rgbrs_pkg::COORD_W + SW;   // col * size
    localparam int NW     = PW + FRAC_BITS;            // dividend / quotient
    localparam int IW     = NW - FRAC_BITS;            // integer part
    localparam int IW1    = IW + 1;
    localparam int CX     = $clog2(MAX_SRC_WIDTH);
    localparam int CY     = $clog2(MAX_SRC_HEIGHT);
    localparam int CM     = (CX > CY) ? CX : CY;
    localparam int HWD    = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HHT    = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BDEPTH = HWD * HHT;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int DW     = rgbrs_pkg::DST_DIM_W;
    localparam int PXW    = rgbrs_pkg::PIX_W;
    localparam logic [NW:0] HALF = (NW + 1)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic smp;   // sample, gives a result
        logic wr;    // load inside the frame
    } t_ctl;

    typedef struct packed {
        logic [CX-1:0]  col;
        logic [CY-1:0]  row;
        logic [PXW-1:0] rgb;
    } t_load;

    typedef struct packed {
        logic [CM-1:0]        lo;
        logic [CM-1:0]        hi;
        logic [FRAC_BITS-1:0] frac;
    } t_axis;

    // ---------------- configuration registers ----------------
    logic [rgbrs_pkg::SRC_DIM_W-1:0] r_src_width, r_src_height;
    logic [DW-1:0]                   r_dst_width, r_dst_height;
    logic                            r_interp_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= rgbrs_pkg::SRC_WIDTH_RST;
            r_src_height  <= rgbrs_pkg::SRC_HEIGHT_RST;
            r_dst_width   <= rgbrs_pkg::DST_WIDTH_RST;
            r_dst_height  <= rgbrs_pkg::DST_HEIGHT_RST;
            r_interp_mode <= rgbrs_pkg::MODE_BILINEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbrs_pkg::REG_SRC_WIDTH:   r_src_width   <= i_cfg_data[rgbrs_pkg::SRC_DIM_W-1:0];
                rgbrs_pkg::REG_SRC_HEIGHT:  r_src_height  <= i_cfg_data[rgbrs_pkg::SRC_DIM_W-1:0];
                rgbrs_pkg::REG_DST_WIDTH:   r_dst_width   <= i_cfg_data;
                rgbrs_pkg::REG_DST_HEIGHT:  r_dst_height  <= i_cfg_data;
                rgbrs_pkg::REG_INTERP_MODE: r_interp_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, source saturates at the store size
    logic [SW-1:0] ws, hs;
    logic [DW-1:0] wd, hd;

    always_comb begin
        if (r_src_width == '0)                         ws = SW'(1);
        else if (32'(r_src_width) > MAX_SRC_WIDTH)     ws = SW'(MAX_SRC_WIDTH);
        else                                           ws = SW'(r_src_width);
        if (r_src_height == '0)                        hs = SW'(1);
        else if (32'(r_src_height) > MAX_SRC_HEIGHT)   hs = SW'(MAX_SRC_HEIGHT);
        else                                           hs = SW'(r_src_height);
        wd = (r_dst_width  == '0) ? DW'(1) : r_dst_width;
        hd = (r_dst_height == '0) ? DW'(1) : r_dst_height;
    end

    assign busy = 1'b0;

    // ---------------- S0: request register ----------------
    logic                           r_s0_valid;
    logic                           r_s0_op;
    logic [rgbrs_pkg::COORD_W-1:0]  r_s0_col, r_s0_row;
    logic [PXW-1:0]                 r_s0_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s0_valid <= 1'b0;
        else          r_s0_valid <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r_s0_op  <= i_operation;
        r_s0_col <= i_col;
        r_s0_row <= i_row;
        r_s0_rgb <= {i_blue_in, i_green_in, i_red_in};
    end

    t_ctl  s0_ctl;
    t_load s0_ld;

    always_comb begin
        s0_ctl.smp = r_s0_valid && (r_s0_op == rgbrs_pkg::OP_SAMPLE);
        s0_ctl.wr  = r_s0_valid && (r_s0_op == rgbrs_pkg::OP_LOAD)
                     && (32'(r_s0_col) < 32'(ws)) && (32'(r_s0_row) < 32'(hs));
        s0_ld.col  = CX'(r_s0_col);
        s0_ld.row  = CY'(r_s0_row);
        s0_ld.rgb  = r_s0_rgb;
    end

    // ---------------- S1: position * source size ----------------
    logic [NW-1:0] r_s1_num_x, r_s1_num_y;

    always_ff @(posedge i_clk) begin
        r_s1_num_x <= {PW'(r_s0_col) * PW'(ws), FRAC_BITS'(0)};
        r_s1_num_y <= {PW'(r_s0_row) * PW'(hs), FRAC_BITS'(0)};
    end

    // request side band runs alongside the dividers
    t_ctl  r_dc [NW+1];
    t_load r_dl [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) r_dc[k] <= '0;
        end else begin
            r_dc[0] <= s0_ctl;
            for (int k = 1; k <= NW; k++) r_dc[k] <= r_dc[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl[0] <= s0_ld;
        for (int k = 1; k <= NW; k++) r_dl[k] <= r_dl[k-1];
    end

    logic [NW-1:0] quo_x, quo_y;

    rgbrs_div #(.NW(NW), .DW(DW)) u_div_x (
        .i_clk (i_clk),
        .i_num (r_s1_num_x),
        .i_den (wd),
        .o_quo (quo_x)
    );

    rgbrs_div #(.NW(NW), .DW(DW)) u_div_y (
        .i_clk (i_clk),
        .i_num (r_s1_num_y),
        .i_den (hd),
        .o_quo (quo_y)
    );

    // ---------------- P1: neighbour coordinates ----------------
    // nearest mode: rounded position with zero fraction and both neighbours
    // on the same pixel, so the blend returns that pixel unchanged
    function automatic t_axis map_axis(input logic [NW-1:0] q,
                                       input logic [SW-1:0] size,
                                       input logic          nearest);
        logic [NW:0]  qr;
        logic [IW:0]  ip;
        logic [SW:0]  last;
        t_axis        a;
        qr   = {1'b0, q} + HALF;
        ip   = nearest ? qr[NW:FRAC_BITS] : {1'b0, q[NW-1:FRAC_BITS]};
        last = SW1'(size) - SW1'(1);
        if (ip >= IW1'(size)) a.lo = CM'(last);
        else                  a.lo = CM'(ip);
        a.hi   = (!nearest && (SW1'(a.lo) + SW1'(1) < SW1'(size))) ? a.lo + CM'(1) : a.lo;
        a.frac = nearest ? '0 : q[FRAC_BITS-1:0];
        return a;
    endfunction

    t_axis ax, ay;
    logic  nearest;

    assign nearest = (r_interp_mode == rgbrs_pkg::MODE_NEAREST);
    assign ax      = map_axis(quo_x, ws, nearest);
    assign ay      = map_axis(quo_y, hs, nearest);

    t_ctl                  r_p1_ctl;
    t_load                 r_p1_ld;
    logic [CX-1:0]         r_p1_x1, r_p1_x2;
    logic [CY-1:0]         r_p1_y1, r_p1_y2;
    logic [FRAC_BITS-1:0]  r_p1_dx, r_p1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_ctl <= '0;
        else          r_p1_ctl <= r_dc[NW];
    end

    always_ff @(posedge i_clk) begin
        r_p1_ld <= r_dl[NW];
        r_p1_x1 <= CX'(ax.lo);
        r_p1_x2 <= CX'(ax.hi);
        r_p1_y1 <= CY'(ay.lo);
        r_p1_y2 <= CY'(ay.hi);
        r_p1_dx <= ax.frac;
        r_p1_dy <= ay.frac;
    end

    // ---------------- P2: bank addressing and store access ----------------
    function automatic logic [BAW-1:0] bank_addr(input logic [CX-1:0] c,
                                                 input logic [CY-1:0] r);
        return BAW'(32'(r >> 1) * HWD + 32'(c >> 1));
    endfunction

    logic [3:0][BAW-1:0] raddr;
    logic [3:0][PXW-1:0] rdata;

    // bank index is {row parity, column parity}; each needed neighbour
    // lands in a bank of its own
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            raddr[b] = bank_addr((r_p1_x1[0] == b[0]) ? r_p1_x1 : r_p1_x2,
                                 (r_p1_y1[0] == b[1]) ? r_p1_y1 : r_p1_y2);
        end
    end

    rgbrs_store #(.DEPTH(BDEPTH), .AW(BAW)) u_store (
        .i_clk   (i_clk),
        .i_we    (r_p1_ctl.wr),
        .i_wbank ({r_p1_ld.row[0], r_p1_ld.col[0]}),
        .i_waddr (bank_addr(r_p1_ld.col, r_p1_ld.row)),
        .i_wdata (r_p1_ld.rgb),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    logic                  r_p2_smp;
    logic                  r_p2_x1p, r_p2_x2p, r_p2_y1p, r_p2_y2p;
    logic [FRAC_BITS-1:0]  r_p2_dx, r_p2_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2_smp <= 1'b0;
        else          r_p2_smp <= r_p1_ctl.smp;
    end

    always_ff @(posedge i_clk) begin
        r_p2_x1p <= r_p1_x1[0];
        r_p2_x2p <= r_p1_x2[0];
        r_p2_y1p <= r_p1_y1[0];
        r_p2_y2p <= r_p1_y2[0];
        r_p2_dx  <= r_p1_dx;
        r_p2_dy  <= r_p1_dy;
    end

    // ---------------- P3: neighbour select and blend ----------------
    logic [3:0][PXW-1:0] nbr;

    always_comb begin
        nbr[0] = rdata[{r_p2_y1p, r_p2_x1p}];
        nbr[1] = rdata[{r_p2_y1p, r_p2_x2p}];
        nbr[2] = rdata[{r_p2_y2p, r_p2_x1p}];
        nbr[3] = rdata[{r_p2_y2p, r_p2_x2p}];
    end

    rgbrs_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p2_smp),
        .i_pix   (nbr),
        .i_dx    (r_p2_dx),
        .i_dy    (r_p2_dy),
        .o_valid (o_strobe),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

endmodule
